@@ hw/rtl/circle_circle_intersection_macros.svh @@
// Assertion macros shared by the circle intersection checker.
`ifndef CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CCI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CCI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cci_pkg.sv @@
// Types and constants of the circle intersection pipeline.
package cci_pkg;

  localparam int KBits      = 126;
  localparam int RootBits   = KBits / 2;
  localparam int SqRemBits  = RootBits + 2;
  localparam int QuoBits    = 33;
  localparam int NumBits    = 98;
  localparam int DivRemBits = 65;
  localparam int D2Bits     = 64;
  localparam int MagBits    = 65;
  localparam int AbsBits    = 33;

  localparam logic [2:0] StInvalid    = 3'd0;
  localparam logic [2:0] StNone       = 3'd1;
  localparam logic [2:0] StCoincident = 3'd2;
  localparam logic [2:0] StExtTangent = 3'd3;
  localparam logic [2:0] StIntTangent = 3'd4;
  localparam logic [2:0] StTwoPoints  = 3'd5;

  typedef struct packed {
    logic signed [31:0] first_center_x;
    logic signed [31:0] first_center_y;
    logic [30:0]        first_radius;
    logic signed [31:0] second_center_x;
    logic signed [31:0] second_center_y;
    logic [30:0]        second_radius;
  } cci_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] point_p_x;
    logic signed [31:0] point_p_y;
    logic signed [31:0] point_q_x;
    logic signed [31:0] point_q_y;
  } cci_out_t;

  typedef struct packed {
    logic [SqRemBits-1:0] rem;
    logic [RootBits-1:0]  root;
    logic [KBits-1:0]     kbits;
  } sq_work_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic               sx;
    logic               sy;
    logic               nneg;
    logic [AbsBits-1:0] adx;
    logic [AbsBits-1:0] ady;
    logic [MagBits-1:0] nmag;
    logic [D2Bits-1:0]  d2;
  } sq_side_t;

  typedef struct packed {
    logic [DivRemBits-1:0] rem;
    logic [QuoBits-1:0]    low;
  } div_work_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic               sx;
    logic               sy;
    logic               nneg;
    logic [D2Bits-1:0]  d2;
  } div_side_t;

endpackage

@@ hw/rtl/cci_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
interface cci_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/circle_circle_intersection.sv @@
// Circle intersection top level: classify two circles and compute their crossing points.
//
// Usage: push a pair of circles (signed Q16.16 centres, unsigned radii) as one beat on
// req_i; one beat with status and points P and Q comes back on rsp_o per input beat, in
// order. Status codes: invalid radius, none, coincident, external tangent, internal
// tangent, two points. Points are zero unless the circles touch or cross.
//
// Throughput: one beat per cycle while rsp_o is not stalled. A beat passes through 7 setup
// stages, the 63-stage square root of the 126-bit chord term (one root bit per stage), two
// product stages, the 33-stage restoring dividers (one quotient bit per stage, four lanes
// side by side) and two output stages before its result appears on rsp_o.
//
// Stalls: the whole pipeline advances together; while rsp_o holds a beat that is not
// taken, every stage holds and req_i.ready is low. Beats are never dropped or repeated.
// Bubbles travel as cleared valid bits, so a new beat enters whenever the output slot is
// empty or being taken.
//
// Reset: rst_ni clears all valid bits at once; the block accepts beats right after.
module circle_circle_intersection (
  input  logic         clk_i,
  input  logic         rst_ni,
  cci_stream_if.sink   req_i,
  cci_stream_if.source rsp_o
);

  localparam int KBits      = cci_pkg::KBits;
  localparam int RootBits   = cci_pkg::RootBits;
  localparam int SqRemBits  = cci_pkg::SqRemBits;
  localparam int QuoBits    = cci_pkg::QuoBits;
  localparam int NumBits    = cci_pkg::NumBits;
  localparam int DivRemBits = cci_pkg::DivRemBits;
  localparam int D2Bits     = cci_pkg::D2Bits;
  localparam int MagBits    = cci_pkg::MagBits;
  localparam int AbsBits    = cci_pkg::AbsBits;
  localparam int Lanes      = 4;

  localparam logic signed [34:0] SatMax = 35'sd2147483647;
  localparam logic signed [34:0] SatMin = -35'sd2147483648;

  function automatic cci_pkg::sq_work_t sq_step(input cci_pkg::sq_work_t w);
    logic [SqRemBits+1:0] t;
    logic [SqRemBits+1:0] trial;
    logic [SqRemBits+1:0] diff;
    logic                 ge;
    cci_pkg::sq_work_t    r;
    t       = {w.rem, w.kbits[KBits-1 -: 2]};
    trial   = {2'b00, w.root, 2'b01};
    diff    = t - trial;
    ge      = (t >= trial);
    r.rem   = ge ? diff[SqRemBits-1:0] : t[SqRemBits-1:0];
    r.root  = {w.root[RootBits-2:0], ge};
    r.kbits = {w.kbits[KBits-3:0], 2'b00};
    return r;
  endfunction

  function automatic cci_pkg::div_work_t div_step(input cci_pkg::div_work_t w,
                                                  input logic [D2Bits-1:0] d2);
    logic [DivRemBits:0] t;
    logic [DivRemBits:0] den;
    logic [DivRemBits:0] diff;
    logic                ge;
    cci_pkg::div_work_t  r;
    t     = {w.rem, w.low[QuoBits-1]};
    den   = {1'b0, d2, 1'b0};
    diff  = t - den;
    ge    = (t >= den);
    r.rem = ge ? diff[DivRemBits-1:0] : t[DivRemBits-1:0];
    r.low = {w.low[QuoBits-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [34:0] c;
    c = v;
    if (v > SatMax) c = SatMax;
    if (v < SatMin) c = SatMin;
    return c[31:0];
  endfunction

  logic en;
  logic out_valid_q;
  cci_pkg::cci_out_t out_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // ---------------- setup stages ----------------
  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;

  logic [32:0]              s1_dx_q, s1_dy_q;
  logic signed [31:0]       s1_x1_q, s1_y1_q;
  logic [30:0]              s1_r1_q, s1_r2_q;

  logic [AbsBits-1:0]       s2_adx_q, s2_ady_q;
  logic                     s2_sx_q, s2_sy_q, s2_zero_q;
  logic [31:0]              s2_rs_q;
  logic [30:0]              s2_rd_q, s2_r1_q, s2_r2_q;
  logic signed [31:0]       s2_x1_q, s2_y1_q;

  logic [65:0]              s3_adx2_q, s3_ady2_q;
  logic [63:0]              s3_s2_q;
  logic [61:0]              s3_m2_q, s3_r1sq_q, s3_r2sq_q;
  logic                     s3_zero_q, s3_sx_q, s3_sy_q;
  logic [AbsBits-1:0]       s3_adx_q, s3_ady_q;
  logic signed [31:0]       s3_x1_q, s3_y1_q;

  logic [65:0]              s4_d2_q;
  logic [63:0]              s4_s2_q;
  logic [61:0]              s4_m2_q, s4_r1sq_q, s4_r2sq_q;
  logic                     s4_zero_q, s4_sx_q, s4_sy_q;
  logic [AbsBits-1:0]       s4_adx_q, s4_ady_q;
  logic signed [31:0]       s4_x1_q, s4_y1_q;

  logic [2:0]               s5_status_d, s5_status_q;
  logic [64:0]              s5_p_q;
  logic [63:0]              s5_ka_q, s5_kb_q;
  logic [D2Bits-1:0]        s5_d2_q;
  logic [61:0]              s5_r2sq_q;
  logic                     s5_sx_q, s5_sy_q;
  logic [AbsBits-1:0]       s5_adx_q, s5_ady_q;
  logic signed [31:0]       s5_x1_q, s5_y1_q;

  logic [2:0]               s6_status_q;
  logic [MagBits-1:0]       s6_nmag_q;
  logic                     s6_nneg_q;
  logic [63:0]              s6_kll_q, s6_klh_q, s6_khl_q, s6_khh_q;
  logic [D2Bits-1:0]        s6_d2_q;
  logic                     s6_sx_q, s6_sy_q;
  logic [AbsBits-1:0]       s6_adx_q, s6_ady_q;
  logic signed [31:0]       s6_x1_q, s6_y1_q;

  logic [127:0]             k_full;

  always_comb begin
    if (s4_zero_q) begin
      s5_status_d = cci_pkg::StInvalid;
    end else if ((s4_d2_q > {2'b00, s4_s2_q}) || (s4_d2_q < {4'b0000, s4_m2_q})) begin
      s5_status_d = cci_pkg::StNone;
    end else if (s4_d2_q == 66'd0) begin
      s5_status_d = cci_pkg::StCoincident;
    end else if (s4_d2_q == {2'b00, s4_s2_q}) begin
      s5_status_d = cci_pkg::StExtTangent;
    end else if (s4_d2_q == {4'b0000, s4_m2_q}) begin
      s5_status_d = cci_pkg::StIntTangent;
    end else begin
      s5_status_d = cci_pkg::StTwoPoints;
    end
  end

  assign k_full = {s6_khh_q, 64'd0} + {32'd0, s6_klh_q, 32'd0}
                + {32'd0, s6_khl_q, 32'd0} + {64'd0, s6_kll_q};

  // ---------------- square root and divider arrays ----------------
  cci_pkg::sq_work_t  sq_q    [0:RootBits];
  cci_pkg::sq_work_t  sq_nxt  [0:RootBits];
  cci_pkg::sq_side_t  sqs_q   [0:RootBits];
  logic               sq_v_q  [0:RootBits];

  logic [64:0]        m_pxl_q, m_pyl_q;
  logic [65:0]        m_pxh_q, m_pyh_q;
  logic [64:0]        m_rxl_q, m_ryl_q;
  logic [63:0]        m_rxh_q, m_ryh_q;
  cci_pkg::div_side_t m_side_q;
  logic               m_v_q;

  logic [NumBits-1:0] num [Lanes];

  cci_pkg::div_work_t dv_q   [0:QuoBits][Lanes];
  cci_pkg::div_work_t dv_nxt [0:QuoBits][Lanes];
  cci_pkg::div_side_t dvs_q  [0:QuoBits];
  logic               dv_v_q [0:QuoBits];

  always_comb begin
    sq_nxt[0] = sq_q[0];
    for (int i = 0; i < RootBits; i++) begin
      sq_nxt[i+1] = sq_step(sq_q[i]);
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      dv_nxt[0][l] = dv_q[0][l];
    end
    for (int i = 0; i < QuoBits; i++) begin
      for (int l = 0; l < Lanes; l++) begin
        dv_nxt[i+1][l] = div_step(dv_q[i][l], dvs_q[i].d2);
      end
    end
  end

  // Lanes: foot x, foot y, offset x, offset y.
  assign num[0] = {m_pxh_q, 32'd0} + {33'd0, m_pxl_q} + {34'd0, m_side_q.d2};
  assign num[1] = {m_pyh_q, 32'd0} + {33'd0, m_pyl_q} + {34'd0, m_side_q.d2};
  assign num[2] = {2'b00, m_rxh_q, 32'd0} + {33'd0, m_rxl_q} + {34'd0, m_side_q.d2};
  assign num[3] = {2'b00, m_ryh_q, 32'd0} + {33'd0, m_ryl_q} + {34'd0, m_side_q.d2};

  // ---------------- output stages ----------------
  logic [2:0]         f1_status_q;
  logic signed [34:0] f1_fx_q, f1_fy_q, f1_hx_q, f1_hy_q;
  logic               f1_v_q;
  logic [QuoBits-1:0] q_fx, q_fy, q_hx, q_hy;
  logic [34:0]        x1_ext, y1_ext;
  logic               pts_zero;
  cci_pkg::div_side_t ls;

  assign ls     = dvs_q[QuoBits];
  assign q_fx   = dv_q[QuoBits][0].low;
  assign q_fy   = dv_q[QuoBits][1].low;
  assign q_hx   = dv_q[QuoBits][2].low;
  assign q_hy   = dv_q[QuoBits][3].low;
  assign x1_ext = {{3{ls.x1[31]}}, ls.x1};
  assign y1_ext = {{3{ls.y1[31]}}, ls.y1};

  assign pts_zero = (f1_status_q == cci_pkg::StInvalid) || (f1_status_q == cci_pkg::StNone)
                 || (f1_status_q == cci_pkg::StCoincident);

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      m_v_q       <= 1'b0;
      f1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= RootBits; i++) sq_v_q[i] <= 1'b0;
      for (int i = 0; i <= QuoBits; i++) dv_v_q[i] <= 1'b0;
    end else if (en) begin
      s1_v_q    <= req_i.valid;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      s5_v_q    <= s4_v_q;
      s6_v_q    <= s5_v_q;
      sq_v_q[0] <= s6_v_q;
      for (int i = 0; i < RootBits; i++) sq_v_q[i+1] <= sq_v_q[i];
      m_v_q     <= sq_v_q[RootBits];
      dv_v_q[0] <= m_v_q;
      for (int i = 0; i < QuoBits; i++) dv_v_q[i+1] <= dv_v_q[i];
      f1_v_q      <= dv_v_q[QuoBits];
      out_valid_q <= f1_v_q;
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      // differences
      s1_dx_q <= {req_i.data.second_center_x[31], req_i.data.second_center_x}
               - {req_i.data.first_center_x[31], req_i.data.first_center_x};
      s1_dy_q <= {req_i.data.second_center_y[31], req_i.data.second_center_y}
               - {req_i.data.first_center_y[31], req_i.data.first_center_y};
      s1_x1_q <= req_i.data.first_center_x;
      s1_y1_q <= req_i.data.first_center_y;
      s1_r1_q <= req_i.data.first_radius;
      s1_r2_q <= req_i.data.second_radius;

      // magnitudes, radius sum and difference
      s2_adx_q  <= s1_dx_q[32] ? (~s1_dx_q + 33'd1) : s1_dx_q;
      s2_ady_q  <= s1_dy_q[32] ? (~s1_dy_q + 33'd1) : s1_dy_q;
      s2_sx_q   <= s1_dx_q[32];
      s2_sy_q   <= s1_dy_q[32];
      s2_rs_q   <= {1'b0, s1_r1_q} + {1'b0, s1_r2_q};
      s2_rd_q   <= (s1_r1_q > s1_r2_q) ? (s1_r1_q - s1_r2_q) : (s1_r2_q - s1_r1_q);
      s2_zero_q <= (s1_r1_q == 31'd0) || (s1_r2_q == 31'd0);
      s2_r1_q   <= s1_r1_q;
      s2_r2_q   <= s1_r2_q;
      s2_x1_q   <= s1_x1_q;
      s2_y1_q   <= s1_y1_q;

      // squares
      s3_adx2_q <= s2_adx_q * s2_adx_q;
      s3_ady2_q <= s2_ady_q * s2_ady_q;
      s3_s2_q   <= s2_rs_q * s2_rs_q;
      s3_m2_q   <= s2_rd_q * s2_rd_q;
      s3_r1sq_q <= s2_r1_q * s2_r1_q;
      s3_r2sq_q <= s2_r2_q * s2_r2_q;
      s3_zero_q <= s2_zero_q;
      s3_sx_q   <= s2_sx_q;
      s3_sy_q   <= s2_sy_q;
      s3_adx_q  <= s2_adx_q;
      s3_ady_q  <= s2_ady_q;
      s3_x1_q   <= s2_x1_q;
      s3_y1_q   <= s2_y1_q;

      s4_d2_q   <= s3_adx2_q + s3_ady2_q;
      s4_s2_q   <= s3_s2_q;
      s4_m2_q   <= s3_m2_q;
      s4_r1sq_q <= s3_r1sq_q;
      s4_r2sq_q <= s3_r2sq_q;
      s4_zero_q <= s3_zero_q;
      s4_sx_q   <= s3_sx_q;
      s4_sy_q   <= s3_sy_q;
      s4_adx_q  <= s3_adx_q;
      s4_ady_q  <= s3_ady_q;
      s4_x1_q   <= s3_x1_q;
      s4_y1_q   <= s3_y1_q;

      // classify; d2 fits 64 bits whenever points are needed
      s5_status_q <= s5_status_d;
      s5_p_q      <= {1'b0, s4_d2_q[D2Bits-1:0]} + {3'b000, s4_r1sq_q};
      s5_ka_q     <= s4_s2_q - s4_d2_q[D2Bits-1:0];
      s5_kb_q     <= s4_d2_q[D2Bits-1:0] - {2'b00, s4_m2_q};
      s5_d2_q     <= s4_d2_q[D2Bits-1:0];
      s5_r2sq_q   <= s4_r2sq_q;
      s5_sx_q     <= s4_sx_q;
      s5_sy_q     <= s4_sy_q;
      s5_adx_q    <= s4_adx_q;
      s5_ady_q    <= s4_ady_q;
      s5_x1_q     <= s4_x1_q;
      s5_y1_q     <= s4_y1_q;

      s6_status_q <= s5_status_q;
      s6_nneg_q   <= (s5_p_q < {3'b000, s5_r2sq_q});
      s6_nmag_q   <= (s5_p_q >= {3'b000, s5_r2sq_q}) ? (s5_p_q - {3'b000, s5_r2sq_q})
                                                     : ({3'b000, s5_r2sq_q} - s5_p_q);
      s6_kll_q    <= s5_ka_q[31:0]  * s5_kb_q[31:0];
      s6_klh_q    <= s5_ka_q[31:0]  * s5_kb_q[63:32];
      s6_khl_q    <= s5_ka_q[63:32] * s5_kb_q[31:0];
      s6_khh_q    <= s5_ka_q[63:32] * s5_kb_q[63:32];
      s6_d2_q     <= s5_d2_q;
      s6_sx_q     <= s5_sx_q;
      s6_sy_q     <= s5_sy_q;
      s6_adx_q    <= s5_adx_q;
      s6_ady_q    <= s5_ady_q;
      s6_x1_q     <= s5_x1_q;
      s6_y1_q     <= s5_y1_q;

      // load the square root array
      sq_q[0].rem    <= '0;
      sq_q[0].root   <= '0;
      sq_q[0].kbits  <= k_full[KBits-1:0];
      sqs_q[0].status <= s6_status_q;
      sqs_q[0].x1     <= s6_x1_q;
      sqs_q[0].y1     <= s6_y1_q;
      sqs_q[0].sx     <= s6_sx_q;
      sqs_q[0].sy     <= s6_sy_q;
      sqs_q[0].nneg   <= s6_nneg_q;
      sqs_q[0].adx    <= s6_adx_q;
      sqs_q[0].ady    <= s6_ady_q;
      sqs_q[0].nmag   <= s6_nmag_q;
      sqs_q[0].d2     <= s6_d2_q;
      for (int i = 0; i < RootBits; i++) begin
        sq_q[i+1]  <= sq_nxt[i+1];
        sqs_q[i+1] <= sqs_q[i];
      end

      // partial products for the four scaled terms
      m_pxl_q <= sqs_q[RootBits].nmag[31:0] * sqs_q[RootBits].adx;
      m_pxh_q <= sqs_q[RootBits].nmag[MagBits-1:32] * sqs_q[RootBits].adx;
      m_pyl_q <= sqs_q[RootBits].nmag[31:0] * sqs_q[RootBits].ady;
      m_pyh_q <= sqs_q[RootBits].nmag[MagBits-1:32] * sqs_q[RootBits].ady;
      m_rxl_q <= sq_q[RootBits].root[31:0] * sqs_q[RootBits].adx;
      m_rxh_q <= sq_q[RootBits].root[RootBits-1:32] * sqs_q[RootBits].adx;
      m_ryl_q <= sq_q[RootBits].root[31:0] * sqs_q[RootBits].ady;
      m_ryh_q <= sq_q[RootBits].root[RootBits-1:32] * sqs_q[RootBits].ady;
      m_side_q.status <= sqs_q[RootBits].status;
      m_side_q.x1     <= sqs_q[RootBits].x1;
      m_side_q.y1     <= sqs_q[RootBits].y1;
      m_side_q.sx     <= sqs_q[RootBits].sx;
      m_side_q.sy     <= sqs_q[RootBits].sy;
      m_side_q.nneg   <= sqs_q[RootBits].nneg;
      m_side_q.d2     <= sqs_q[RootBits].d2;

      // load the dividers; adding d2 rounds the quotient to nearest
      for (int l = 0; l < Lanes; l++) begin
        dv_q[0][l].rem <= num[l][NumBits-1:QuoBits];
        dv_q[0][l].low <= num[l][QuoBits-1:0];
      end
      dvs_q[0] <= m_side_q;
      for (int i = 0; i < QuoBits; i++) begin
        for (int l = 0; l < Lanes; l++) begin
          dv_q[i+1][l] <= dv_nxt[i+1][l];
        end
        dvs_q[i+1] <= dvs_q[i];
      end

      // signed foot point and offsets
      f1_status_q <= ls.status;
      f1_fx_q <= (ls.nneg != ls.sx) ? (x1_ext - {2'b00, q_fx}) : (x1_ext + {2'b00, q_fx});
      f1_fy_q <= (ls.nneg != ls.sy) ? (y1_ext - {2'b00, q_fy}) : (y1_ext + {2'b00, q_fy});
      f1_hx_q <= ls.sx ? (35'd0 - {2'b00, q_hx}) : {2'b00, q_hx};
      f1_hy_q <= ls.sy ? (35'd0 - {2'b00, q_hy}) : {2'b00, q_hy};

      // combine, saturate, zero the unused points
      out_q.status <= f1_status_q;
      if (pts_zero) begin
        out_q.point_p_x <= '0;
        out_q.point_p_y <= '0;
        out_q.point_q_x <= '0;
        out_q.point_q_y <= '0;
      end else begin
        out_q.point_p_x <= sat32(f1_fx_q - f1_hy_q);
        out_q.point_p_y <= sat32(f1_fy_q + f1_hx_q);
        out_q.point_q_x <= sat32(f1_fx_q + f1_hy_q);
        out_q.point_q_y <= sat32(f1_fy_q - f1_hx_q);
      end
    end
  end

endmodule

@@ hw/rtl/cci_checker.sv @@
// Port-level checks of the circle intersection block, bound to its top level.
`include "circle_circle_intersection_macros.svh"

module cci_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input cci_pkg::cci_out_t out_data_i
);

  logic no_pts;
  logic tangent;
  logic unused_valid;

  assign unused_valid = in_valid_i;

  assign no_pts  = (out_data_i.status == cci_pkg::StInvalid)
                || (out_data_i.status == cci_pkg::StNone)
                || (out_data_i.status == cci_pkg::StCoincident);
  assign tangent = (out_data_i.status == cci_pkg::StExtTangent)
                || (out_data_i.status == cci_pkg::StIntTangent);

  `CCI_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result beat changed")
  `CCI_ASSERT_IMP(a_stall_blocks_in, out_valid_i && !out_ready_i, !in_ready_i || !unused_valid || !in_valid_i, "input taken while output stalled")
  `CCI_ASSERT_IMP(a_zero_points, out_valid_i && no_pts, (out_data_i.point_p_x == 0) && (out_data_i.point_p_y == 0) && (out_data_i.point_q_x == 0) && (out_data_i.point_q_y == 0), "points not zero without intersection")
  `CCI_ASSERT_IMP(a_tangent_same, out_valid_i && tangent, (out_data_i.point_p_x == out_data_i.point_q_x) && (out_data_i.point_p_y == out_data_i.point_q_y), "tangent points differ")

endmodule

bind circle_circle_intersection cci_checker u_cci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.data)
);
